@@ src/cpi_pkg.sv @@
// cpi_pkg: shared types and constants for the colour palette indexer.
// No dependencies; used by colour_palette_indexer and cpi_checker.
`default_nettype none

package cpi_pkg;

    localparam int PALETTE_DEPTH_DEF = 256;
    // palette_index is 8 bits, so no more than 256 colours can be named
    localparam int INDEX_LIMIT       = 256;
    localparam int COLOUR_W          = 24;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_BAD_PAD = 2'd1,
        ST_FULL    = 2'd2
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SEARCH,
        S_MISS,
        S_FINISH
    } t_state;

    typedef struct packed {
        logic       new_image;
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic [7:0] pad_byte;
    } t_in;

    typedef struct packed {
        logic [7:0] palette_index;
        logic [1:0] status;
    } t_out;

endpackage

`default_nettype wire

@@ src/cpi_ram.sv @@
// cpi_ram: generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module cpi_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 256
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

@@ src/colour_palette_indexer.sv @@
// colour_palette_indexer: top level, search sequencer and result register.
// Depends on cpi_pkg and cpi_ram.
`default_nettype none

// Builds an indexed palette from a stream of RGB pixels, one pixel per input
// transaction and exactly one result transaction per pixel. The pixel's
// channels are packed as {red, green, blue}; the stored palette is scanned
// one entry per clock through the palette RAM's single registered read port.
// A hit returns the stored index with status OK; a miss appends the colour at
// the next free entry and returns that index. A nonzero pad byte returns
// status BAD_PAD, index 0, and leaves the palette untouched. A miss with the
// palette at capacity (min(PALETTE_DEPTH, 256) colours) returns status FULL,
// index 0. new_image empties the palette before the pixel is handled, even
// when the pad byte is bad. Timing: the input is ready only while no pixel is
// in flight. A bad-pad pixel passes from acceptance straight to the final step
// and from there into the result register; any other pixel first scans the
// stored entries in order up to a hit, and a miss then passes through a step
// that appends the colour (an empty palette skips the scan). The input is ready
// again once the result is loaded, so the longest gap between accepts comes
// with a miss on a full palette, set by the one-entry-per-cycle RAM scan.
// A previous result that has not been taken holds the sequencer in its final
// step. The result register lets the next pixel be accepted while a result
// waits to be taken. Palette RAM contents are not cleared at reset; the entry
// count alone decides what is valid.

module colour_palette_indexer #(
    parameter int PALETTE_DEPTH = cpi_pkg::PALETTE_DEPTH_DEF
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_in_valid,
    output logic               o_in_ready,
    input  wire cpi_pkg::t_in  i_in_data,
    output logic               o_out_valid,
    input  wire logic          i_out_ready,
    output cpi_pkg::t_out      o_out_data
);

    // usable entries, limited by the 8-bit index
    localparam int CAP = (PALETTE_DEPTH < cpi_pkg::INDEX_LIMIT) ?
                         PALETTE_DEPTH : cpi_pkg::INDEX_LIMIT;
    localparam int AW  = $clog2(CAP);     // RAM address width
    localparam int CW  = $clog2(CAP + 1); // count, can hold CAP itself

    cpi_pkg::t_state             r_state,     n_state;
    logic [cpi_pkg::COLOUR_W-1:0] r_colour,   n_colour;
    logic [CW-1:0]               r_count,     n_count;
    logic [CW-1:0]               r_rd_idx,    n_rd_idx;   // next entry to read
    logic [AW-1:0]               r_cmp_idx,   n_cmp_idx;  // entry now on rdata
    logic                        r_cmp_valid, n_cmp_valid;
    logic                        r_cmp_last,  n_cmp_last; // rdata is last entry
    logic [7:0]                  r_res_idx,   n_res_idx;
    logic [1:0]                  r_res_st,    n_res_st;
    logic                        r_out_valid, n_out_valid;
    cpi_pkg::t_out               r_out_data,  n_out_data;

    logic                         ram_we;
    logic [AW-1:0]                ram_waddr;
    logic [AW-1:0]                ram_raddr;
    logic [cpi_pkg::COLOUR_W-1:0] ram_rdata;
    logic                         issue;

    cpi_ram #(
        .WIDTH (cpi_pkg::COLOUR_W),
        .DEPTH (CAP)
    ) u_palette (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (r_colour),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= cpi_pkg::S_IDLE;
            r_count     <= '0;
            r_cmp_valid <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_cmp_valid <= n_cmp_valid;
            r_out_valid <= n_out_valid;
        end
    end

    // payload and scan bookkeeping
    always_ff @(posedge i_clk) begin
        r_colour   <= n_colour;
        r_rd_idx   <= n_rd_idx;
        r_cmp_idx  <= n_cmp_idx;
        r_cmp_last <= n_cmp_last;
        r_res_idx  <= n_res_idx;
        r_res_st   <= n_res_st;
        r_out_data <= n_out_data;
    end

    assign ram_raddr = r_rd_idx[AW-1:0];
    assign ram_waddr = r_count[AW-1:0];
    // only entries below the count are read
    assign issue     = (r_rd_idx < r_count);

    always_comb begin
        n_state     = r_state;
        n_colour    = r_colour;
        n_count     = r_count;
        n_rd_idx    = r_rd_idx;
        n_cmp_idx   = r_cmp_idx;
        n_cmp_valid = 1'b0;
        n_cmp_last  = r_cmp_last;
        n_res_idx   = r_res_idx;
        n_res_st    = r_res_st;
        n_out_data  = r_out_data;
        ram_we      = 1'b0;
        // result register drains independently of the sequencer
        n_out_valid = r_out_valid && !i_out_ready;

        case (r_state)
            cpi_pkg::S_IDLE: begin
                if (i_in_valid) begin
                    n_colour = {i_in_data.red, i_in_data.green, i_in_data.blue};
                    n_count  = i_in_data.new_image ? '0 : r_count;
                    n_rd_idx = '0;
                    if (i_in_data.pad_byte != 8'd0) begin
                        n_res_idx = 8'd0;
                        n_res_st  = cpi_pkg::ST_BAD_PAD;
                        n_state   = cpi_pkg::S_FINISH;
                    end else if (n_count == '0) begin
                        n_state = cpi_pkg::S_MISS;
                    end else begin
                        n_state = cpi_pkg::S_SEARCH;
                    end
                end
            end
            cpi_pkg::S_SEARCH: begin
                // read of one entry overlaps the compare of the previous one
                n_cmp_valid = issue;
                n_cmp_idx   = r_rd_idx[AW-1:0];
                n_cmp_last  = ((r_rd_idx + 1'b1) == r_count);
                if (issue) begin
                    n_rd_idx = r_rd_idx + 1'b1;
                end
                if (r_cmp_valid && (ram_rdata == r_colour)) begin
                    n_cmp_valid = 1'b0;
                    n_res_idx   = 8'(r_cmp_idx);
                    n_res_st    = cpi_pkg::ST_OK;
                    n_state     = cpi_pkg::S_FINISH;
                end else if (r_cmp_valid && r_cmp_last) begin
                    n_cmp_valid = 1'b0;
                    n_state     = cpi_pkg::S_MISS;
                end
            end
            cpi_pkg::S_MISS: begin
                if (r_count == CW'(CAP)) begin
                    n_res_idx = 8'd0;
                    n_res_st  = cpi_pkg::ST_FULL;
                end else begin
                    ram_we    = 1'b1;
                    n_res_idx = 8'(r_count);
                    n_res_st  = cpi_pkg::ST_OK;
                    n_count   = r_count + 1'b1;
                end
                n_state = cpi_pkg::S_FINISH;
            end
            cpi_pkg::S_FINISH: begin
                // wait for the result register to be free
                if (!r_out_valid || i_out_ready) begin
                    n_out_valid               = 1'b1;
                    n_out_data.palette_index  = r_res_idx;
                    n_out_data.status         = r_res_st;
                    n_state                   = cpi_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = cpi_pkg::S_IDLE;
            end
        endcase
    end

    assign o_in_ready  = (r_state == cpi_pkg::S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

endmodule

`default_nettype wire

@@ src/cpi_checker.sv @@
// cpi_checker: port-level assertions for colour_palette_indexer, plus bind.
// Depends on cpi_pkg.
`default_nettype none

module cpi_checker (
    input wire logic          i_clk,
    input wire logic          i_rst_n,
    input wire logic          i_in_valid,
    input wire logic          o_in_ready,
    input wire logic          o_out_valid,
    input wire logic          i_out_ready,
    input wire cpi_pkg::t_out o_out_data
);

    // status code 3 is never produced
    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_data.status == cpi_pkg::ST_OK ||
                         o_out_data.status == cpi_pkg::ST_BAD_PAD ||
                         o_out_data.status == cpi_pkg::ST_FULL))
        else $error("illegal status code");

    // error results carry index 0
    a_err_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.status != cpi_pkg::ST_OK)
            |-> (o_out_data.palette_index == 8'd0))
        else $error("nonzero index with error status");

    // one pixel in flight: ready drops after an accepted transaction
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready)
        else $error("input ready right after accept");

    // a pending result holds until taken
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=> (o_out_valid && $stable(o_out_data)))
        else $error("result dropped or changed while stalled");

endmodule

bind colour_palette_indexer cpi_checker u_cpi_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_ready  (o_in_ready),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_data  (o_out_data)
);

`default_nettype wire
